// ===== rtl/s2dt_pkg.sv =====
// Shared types, character codes and place weights for the signed decimal text formatter.
`timescale 1ns / 1ps
`default_nettype none

package s2dt_pkg;

    localparam int VALUE_W = 16;
    localparam int MAG_W = VALUE_W + 1;
    localparam int CHAR_W = 6;
    localparam int NUM_PLACE = 4;
    localparam int DIGIT_W = 4;
    localparam int MAX_DIGIT = 9;

    localparam logic [CHAR_W-1:0] CHR_ZERO = 6'h30;
    localparam logic [CHAR_W-1:0] CHR_BLANK = 6'h20;
    localparam logic [CHAR_W-1:0] CHR_MINUS = 6'h2D;

    typedef enum logic [1:0] {
        PLACE_TEN_THOUSANDS = 2'd0,
        PLACE_THOUSANDS     = 2'd1,
        PLACE_HUNDREDS      = 2'd2,
        PLACE_TENS          = 2'd3
    } place_t;

    typedef logic [MAG_W-1:0] mag_t;

    typedef struct packed {
        logic                             neg;
        mag_t                             rem;
        logic                             seen;
        logic [NUM_PLACE-1:0][CHAR_W-1:0] chars;
    } work_t;

    typedef struct packed {
        logic [CHAR_W-1:0] sign_char;
        logic [CHAR_W-1:0] ten_thousands_char;
        logic [CHAR_W-1:0] thousands_char;
        logic [CHAR_W-1:0] hundreds_char;
        logic [CHAR_W-1:0] tens_char;
        logic [CHAR_W-1:0] units_char;
    } result_t;

    function automatic mag_t place_weight(input place_t place);
        mag_t w;
        unique case (place)
            PLACE_TEN_THOUSANDS: w = 17'd10000;
            PLACE_THOUSANDS:     w = 17'd1000;
            PLACE_HUNDREDS:      w = 17'd100;
            PLACE_TENS:          w = 17'd10;
            default:             w = 17'd10;
        endcase
        return w;
    endfunction

endpackage

`default_nettype wire

// ===== rtl/s2dt_operand_if.sv =====
// Valid/ready channel that carries one signed input value per transaction.
`timescale 1ns / 1ps
`default_nettype none

interface s2dt_operand_if;
    logic                                valid;
    logic                                ready;
    logic signed [s2dt_pkg::VALUE_W-1:0] value;

    modport source (output valid, output value, input ready);
    modport sink (input valid, input value, output ready);
endinterface

`default_nettype wire

// ===== rtl/s2dt_result_if.sv =====
// Valid/ready channel that carries one six-character text field per transaction.
`timescale 1ns / 1ps
`default_nettype none

interface s2dt_result_if;
    logic                          valid;
    logic                          ready;
    logic [s2dt_pkg::CHAR_W-1:0]   sign_char;
    logic [s2dt_pkg::CHAR_W-1:0]   ten_thousands_char;
    logic [s2dt_pkg::CHAR_W-1:0]   thousands_char;
    logic [s2dt_pkg::CHAR_W-1:0]   hundreds_char;
    logic [s2dt_pkg::CHAR_W-1:0]   tens_char;
    logic [s2dt_pkg::CHAR_W-1:0]   units_char;

    modport source (
        output valid, output sign_char, output ten_thousands_char, output thousands_char,
        output hundreds_char, output tens_char, output units_char, input ready
    );
    modport sink (
        input valid, input sign_char, input ten_thousands_char, input thousands_char,
        input hundreds_char, input tens_char, input units_char, output ready
    );
endinterface

`default_nettype wire

// ===== rtl/s2dt_digit_stage.sv =====
// Pipeline stage that extracts one decimal digit and applies leading-zero blanking.
`timescale 1ns / 1ps
`default_nettype none

module s2dt_digit_stage (
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  wire s2dt_pkg::place_t place,
    input  wire logic            in_valid,
    output logic                 in_ready,
    input  wire s2dt_pkg::work_t in_data,
    output logic                 out_valid,
    input  wire logic            out_ready,
    output s2dt_pkg::work_t      out_data
);

    logic                              valid_reg;
    s2dt_pkg::work_t                   data_reg;
    s2dt_pkg::work_t                   data_next;
    s2dt_pkg::mag_t                    weight;
    s2dt_pkg::mag_t                    sub;
    logic [s2dt_pkg::DIGIT_W-1:0]      digit;
    logic                              show;

    always_comb
    begin
        weight = s2dt_pkg::place_weight(place);
        digit = '0;
        sub = '0;
        for (int d = 1; d <= s2dt_pkg::MAX_DIGIT; d++)
        begin
            if (in_data.rem >= s2dt_pkg::MAG_W'(d) * weight)
            begin
                digit = s2dt_pkg::DIGIT_W'(d);
                sub = s2dt_pkg::MAG_W'(d) * weight;
            end
        end
        show = (digit != '0) || in_data.seen;
        data_next = in_data;
        data_next.rem = in_data.rem - sub;
        data_next.seen = show;
        data_next.chars[place] = show ?
            s2dt_pkg::CHAR_W'(s2dt_pkg::CHR_ZERO + s2dt_pkg::CHAR_W'(digit)) :
            s2dt_pkg::CHR_BLANK;
    end

    assign in_ready = !valid_reg || out_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_ready && in_valid)
        begin
            data_reg <= data_next;
        end
    end

    assign out_valid = valid_reg;
    assign out_data = data_reg;

endmodule

`default_nettype wire

// ===== rtl/signed_integer_to_decimal_text.sv =====
// Top level: converts a signed 16-bit value into a right-aligned six-character ASCII field.
// Throughput is one transaction per cycle while the result side is not stalled, through an
// entry register, one register stage per extracted digit (ten thousands, thousands, hundreds,
// tens) and an output register. Every stage holds its data while the next one is stalled.
// Reset is asynchronous and clears the valid bit of every stage; data registers are not reset.
`timescale 1ns / 1ps
`default_nettype none

module signed_integer_to_decimal_text (
    input  wire logic        clk,
    input  wire logic        rst_n,
    s2dt_operand_if.sink     operand,
    s2dt_result_if.source    result
);

    logic                    link_valid [s2dt_pkg::NUM_PLACE+1];
    logic                    link_ready [s2dt_pkg::NUM_PLACE+1];
    s2dt_pkg::work_t         link_data  [s2dt_pkg::NUM_PLACE+1];

    logic                    entry_valid_reg;
    s2dt_pkg::work_t         entry_data_reg;
    s2dt_pkg::work_t         entry_data_next;

    logic                    out_valid_reg;
    s2dt_pkg::result_t       out_data_reg;
    s2dt_pkg::result_t       out_data_next;
    s2dt_pkg::work_t         last;

    // Entry stage: sign and 17-bit magnitude, so the most negative value does not overflow.
    always_comb
    begin
        entry_data_next.neg = operand.value[s2dt_pkg::VALUE_W-1];
        entry_data_next.rem = operand.value[s2dt_pkg::VALUE_W-1] ?
            s2dt_pkg::MAG_W'(s2dt_pkg::MAG_W'(0) - {operand.value[s2dt_pkg::VALUE_W-1],
                                                     operand.value}) :
            {1'b0, operand.value};
        entry_data_next.seen = 1'b0;
        entry_data_next.chars = '0;
    end

    assign operand.ready = !entry_valid_reg || link_ready[0];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            entry_valid_reg <= 1'b0;
        end
        else if (operand.ready)
        begin
            entry_valid_reg <= operand.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (operand.ready && operand.valid)
        begin
            entry_data_reg <= entry_data_next;
        end
    end

    assign link_valid[0] = entry_valid_reg;
    assign link_data[0] = entry_data_reg;

    for (genvar i = 0; i < s2dt_pkg::NUM_PLACE; i++)
    begin : g_digit
        s2dt_digit_stage u_stage (
            .clk       (clk),
            .rst_n     (rst_n),
            .place     (s2dt_pkg::place_t'(2'(i))),
            .in_valid  (link_valid[i]),
            .in_ready  (link_ready[i]),
            .in_data   (link_data[i]),
            .out_valid (link_valid[i+1]),
            .out_ready (link_ready[i+1]),
            .out_data  (link_data[i+1])
        );
    end

    // Output stage: the remainder left after the tens digit is the units digit.
    always_comb
    begin
        last = link_data[s2dt_pkg::NUM_PLACE];
        out_data_next.sign_char = last.neg ? s2dt_pkg::CHR_MINUS : s2dt_pkg::CHR_BLANK;
        out_data_next.ten_thousands_char = last.chars[s2dt_pkg::PLACE_TEN_THOUSANDS];
        out_data_next.thousands_char = last.chars[s2dt_pkg::PLACE_THOUSANDS];
        out_data_next.hundreds_char = last.chars[s2dt_pkg::PLACE_HUNDREDS];
        out_data_next.tens_char = last.chars[s2dt_pkg::PLACE_TENS];
        out_data_next.units_char = s2dt_pkg::CHAR_W'(s2dt_pkg::CHR_ZERO +
            s2dt_pkg::CHAR_W'(last.rem[s2dt_pkg::DIGIT_W-1:0]));
    end

    assign link_ready[s2dt_pkg::NUM_PLACE] = !out_valid_reg || result.ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (link_ready[s2dt_pkg::NUM_PLACE])
        begin
            out_valid_reg <= link_valid[s2dt_pkg::NUM_PLACE];
        end
    end

    always_ff @(posedge clk)
    begin
        if (link_ready[s2dt_pkg::NUM_PLACE] && link_valid[s2dt_pkg::NUM_PLACE])
        begin
            out_data_reg <= out_data_next;
        end
    end

    assign result.valid = out_valid_reg;
    assign result.sign_char = out_data_reg.sign_char;
    assign result.ten_thousands_char = out_data_reg.ten_thousands_char;
    assign result.thousands_char = out_data_reg.thousands_char;
    assign result.hundreds_char = out_data_reg.hundreds_char;
    assign result.tens_char = out_data_reg.tens_char;
    assign result.units_char = out_data_reg.units_char;

endmodule

`default_nettype wire
